FILE: src/itdc_pkg.sv
// Shared constants and types for the integer to decimal character unit.
`default_nettype none

package itdc_pkg;

  // Input word and output character widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;

  // Longest decimal form of a 32-bit magnitude
  localparam int unsigned MaxDigits = 10;

  // Character codes
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharTerm = 8'h00;

  // Reciprocal of ten scaled by 2^35, exact for every 32-bit dividend
  localparam logic [ValueW-1:0] Recip10  = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShr = 35;

  // Quotient of a 32-bit value by ten fits in 29 bits
  localparam int unsigned QuotW = ValueW - 3;

  // Result of one divide-by-ten step
  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic [3:0]       digit;
  } div10_res_t;

endpackage : itdc_pkg

`default_nettype wire

FILE: src/int_to_decimal_chars_unit.sv
// Top level: converts a signed 32-bit word into decimal character words.
//
// Takes one signed 32-bit value on the slave stream and sends its decimal
// digits as 8-bit characters on the master stream, most significant first,
// no leading zeros and no sign, followed by a zero terminator word with tlast
// set. For negative values each character is 0x30 minus the digit of the
// magnitude. An item passes through three phases: the word is taken, the
// shared divide-by-ten unit extracts one digit per step until it finds the
// magnitude at zero, and each character and then the terminator is loaded
// into the output register whenever the master side is free to take it.
// tready stays low from the accepted word until the terminator is loaded
// into the output register.
`default_nettype none

module int_to_decimal_chars_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // tdata: value[31:0]
  input  wire logic [itdc_pkg::ValueW-1:0]  s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: char_code[7:0]
  output logic [itdc_pkg::CharW-1:0]        m_axis_tdata,
  output logic                              m_axis_tvalid,
  output logic                              m_axis_tlast,
  input  wire logic                         m_axis_tready
);
  import itdc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxDigits + 1);
  localparam int unsigned IdxW = $clog2(MaxDigits);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [ValueW-1:0] mag_q;
  logic              neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [3:0]        digs_q [MaxDigits];
  logic [CharW-1:0]  data_q;
  logic              valid_q;
  logic              last_q;

  div10_res_t        div_res;
  logic [IdxW-1:0]   wr_idx;
  logic [IdxW-1:0]   rd_idx;
  logic [3:0]        rd_digit;
  logic [CharW-1:0]  rd_code;
  logic              out_free;
  logic              in_take;

  // Shared divide-by-ten unit works on the running magnitude
  itdc_div10 u_div10 (
    .dividend_i (mag_q),
    .res_o      (div_res)
  );

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_free = !valid_q || m_axis_tready;

  // Digit store: write at the digit count, read back from the top
  assign wr_idx   = cnt_q[IdxW-1:0];
  assign rd_idx   = IdxW'(cnt_q - CntW'(1));
  assign rd_digit = digs_q[rd_idx];
  assign rd_code  = neg_q ? (CharZero - {4'b0000, rd_digit})
                          : (CharZero + {4'b0000, rd_digit});

  // Hold extracted digits
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && mag_q != '0) begin
      digs_q[wr_idx] <= div_res.digit;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      data_q  <= CharTerm;
      mag_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (valid_q && m_axis_tready) begin
            valid_q <= 1'b0;
          end
          if (in_take) begin
            neg_q   <= s_axis_tdata[ValueW-1];
            mag_q   <= s_axis_tdata[ValueW-1] ? (~s_axis_tdata + ValueW'(1)) : s_axis_tdata;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (valid_q && m_axis_tready) begin
            valid_q <= 1'b0;
          end
          if (mag_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            mag_q <= {3'b000, div_res.quot};
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            valid_q <= 1'b1;
            if (cnt_q != '0) begin
              data_q <= rd_code;
              last_q <= 1'b0;
              cnt_q  <= cnt_q - CntW'(1);
            end else begin
              data_q  <= CharTerm;
              last_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tdata  = data_q;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last_q;

endmodule : int_to_decimal_chars_unit

`default_nettype wire

FILE: src/itdc_div10.sv
// Divide-by-ten unit: quotient by reciprocal multiply, digit from the low bits.
`default_nettype none

module itdc_div10 (
  input  wire logic [itdc_pkg::ValueW-1:0] dividend_i,
  output itdc_pkg::div10_res_t             res_o
);
  import itdc_pkg::*;

  logic [2*ValueW-1:0] prod;
  logic [QuotW-1:0]    quot;
  logic [3:0]          quot10_lo;

  // Multiply by the scaled reciprocal and keep the top bits
  assign prod = {{ValueW{1'b0}}, dividend_i} * {{ValueW{1'b0}}, Recip10};
  assign quot = prod[2*ValueW-1:RecipShr];

  // Low four bits of quot*10 are enough since the digit is below ten
  assign quot10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};

  assign res_o.quot  = quot;
  assign res_o.digit = dividend_i[3:0] - quot10_lo;

endmodule : itdc_div10

`default_nettype wire

FILE: src/itdc_checker.sv
// Port-level checks for the integer to decimal character unit, with bind.
`default_nettype none

module itdc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic [itdc_pkg::ValueW-1:0] s_axis_tdata,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [itdc_pkg::CharW-1:0]  m_axis_tdata,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tlast,
  input wire logic                        m_axis_tready
);
  import itdc_pkg::*;

  // Hold an offered input word until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |=> (s_axis_tvalid && $stable(s_axis_tdata)))
    else $error("waiting input word changed");

  // Drop ready right after taking a word
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready stayed high after an input word");

  // Terminator word carries the zero code
  a_term_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CharTerm))
    else $error("last word is not the terminator");

  // Digit words are never zero
  a_digit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata != CharTerm))
    else $error("digit word holds the terminator code");

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule : itdc_checker

bind int_to_decimal_chars_unit itdc_checker u_itdc_checker (.*);

`default_nettype wire

FILE: test/int_to_decimal_chars_unit_tb.sv
// Testbench for the integer to decimal character unit: directed and random streams checked against a predictor.

module int_to_decimal_chars_unit_tb;

  import itdc_pkg::*;

  localparam int unsigned ClkPeriod = 12;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned RandomItems = 147;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldOffAt = 300;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned LimitCycles = 300000;

  // Expected output word: character and end-of-string flag
  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } char_word_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxSparse
  } rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [ValueW-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CharW-1:0]      m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tlast;
  logic                  m_axis_tready = 1'b0;

  logic [ValueW-1:0]     values_pending[$];
  char_word_t            chars_due[$];
  int unsigned           mismatches = 0;

  // Sender burst state
  int unsigned           burst_left = 0;
  int unsigned           gap_left = 0;

  // Receiver stall state
  rx_mode_e              rx_mode = RxOpen;
  int unsigned           rx_phase_left = 0;
  int unsigned           words_taken = 0;
  int unsigned           hold_left = 0;
  logic                  hold_done = 1'b0;

  int_to_decimal_chars_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tready (m_axis_tready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Queue the characters and terminator that one value must produce
  function automatic void predict_chars(logic [ValueW-1:0] value);
    logic [ValueW-1:0] mag;
    logic              neg;
    logic [3:0]        digs[MaxDigits];
    int                nd;
    char_word_t        w;
    neg = value[ValueW-1];
    mag = neg ? (ValueW'(0) - value) : value;
    nd = 0;
    while (mag != '0) begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    // Negative values count down from '0' by the magnitude's digit
    for (int k = nd - 1; k >= 0; k--) begin
      w.code = neg ? (CharZero - CharW'(digs[k])) : (CharZero + CharW'(digs[k]));
      w.last = 1'b0;
      chars_due.push_back(w);
    end
    w.code = CharTerm;
    w.last = 1'b1;
    chars_due.push_back(w);
  endfunction

  // Random value with a random digit count, either sign
  function automatic logic [ValueW-1:0] random_value();
    int unsigned n;
    int unsigned lim;
    logic [ValueW-1:0] v;
    if ($urandom_range(0, 2) == 0) begin
      v = $urandom;
    end else begin
      n = $urandom_range(1, 9);
      lim = 1;
      for (int i = 0; i < n; i++) lim = lim * 10;
      v = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 1) == 1) v = ValueW'(0) - v;
    end
    return v;
  endfunction

  // Driver: offer pending words in bursts, hold a word until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        predict_chars(values_pending.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (values_pending.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= values_pending[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch stall pattern now and then, hold off once for a long stretch
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) words_taken++;
    if (!hold_done && words_taken >= HoldOffAt) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
    end
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_phase_left = $urandom_range(20, 200);
    end else begin
      rx_phase_left--;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RxOpen:   m_axis_tready <= 1'b1;
        RxCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:  m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: compare each taken word with the oldest expected one
  always @(posedge clk_i) begin
    char_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (chars_due.size() == 0) begin
        $error("unexpected word: char_code %h last %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        exp_w = chars_due.pop_front();
        if (m_axis_tdata !== exp_w.code) begin
          $error("char_code: expected %h, got %h", exp_w.code, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== exp_w.last) begin
          $error("last: expected %b, got %b", exp_w.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [ValueW-1:0] directed[$];
    directed = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd1000000000,
      32'd1234567890, -32'sd1234567890, 32'd987654321, -32'sd987654321,
      32'h5555_5555, 32'hAAAA_AAAA, 32'd4096, -32'sd5, 32'd1010101010
    };
    foreach (directed[i]) values_pending.push_back(directed[i]);
    for (int i = 0; i < RandomItems; i++) values_pending.push_back(random_value());

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to be taken, then for every character to arrive
    while (values_pending.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (chars_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
src/itdc_pkg.sv
src/itdc_div10.sv
src/int_to_decimal_chars_unit.sv
src/itdc_checker.sv
test/int_to_decimal_chars_unit_tb.sv
